// ----- rtl/smooth_fft_size_select_unit_assert.svh -----
// Assertion macros used by the smooth FFT size selector top level.
`ifndef SMOOTH_FFT_SIZE_SELECT_UNIT_ASSERT_SVH
`define SMOOTH_FFT_SIZE_SELECT_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFSS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfss assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SFSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfss assertion failed");

`endif

// ----- rtl/sfss_pkg.sv -----
// Package with the mode codes and fixed constants of the smooth FFT size selector.
`timescale 1ns / 1ps

package sfss_pkg;

   // Request mode codes.
   localparam logic [2:0] MODE_UPPER  = 3'd0;
   localparam logic [2:0] MODE_LOWER  = 3'd1;
   localparam logic [2:0] MODE_DOUBLE = 3'd2;
   localparam logic [2:0] MODE_THIRD  = 3'd3;
   localparam logic [2:0] MODE_LPF    = 3'd4;

   // One-third margin: size * 133 + 50, then divided by 100.
   localparam int SCALE_EXTRA_BITS = 8;
   localparam int SCALE_BIAS       = 50;
   localparam int SCALE_DIVISOR    = 100;

   // Lower search starts above 2 * size / 3.
   localparam int LOWER_DIVISOR = 3;

   // Smallest power-of-four size.
   localparam int POW4_MIN = 16;

   // First trial divisor and its square.
   localparam int TRIAL_FIRST    = 2;
   localparam int TRIAL_FIRST_SQ = 4;

endpackage

// ----- rtl/smooth_fft_size_select_unit.sv -----
// Smooth FFT size selector: top level with its sequencer and bit-serial divider.
`timescale 1ns / 1ps
`include "smooth_fft_size_select_unit_assert.svh"

// The block takes one request (size, mode) at a time and answers with one
// result. All arithmetic that needs a division runs through a single
// restoring divider that produces one quotient bit per cycle. A trial
// division in the largest-prime-factor search passes through a test state,
// the divider steps and an update state, and each candidate needs one trial
// division per divisor tried (up to its square root when the candidate is
// prime); a smooth search tries at most half of its window start in
// candidates. The lower mode first runs the divider to find the start of its
// window, and the one-third margin mode runs it to scale the size; the
// double margin needs no division. Power-of-four requests multiply by four
// per step until the size is reached. A new request is taken when the
// sequencer is idle, even while the previous result still waits in the
// output register.
module smooth_fft_size_select_unit #(
   parameter int SIZE_BITS = 20
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic                   csr_wr_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SIZE_BITS-1:0]   req_size,
   input  logic [2:0]             req_mode,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [SIZE_BITS+1:0]   rsp_result
);

   import sfss_pkg::*;

   // Candidate width, divider shift width and its alignment pad.
   localparam int CW    = SIZE_BITS + 2;
   localparam int DW    = SIZE_BITS + SCALE_EXTRA_BITS;
   localparam int PAD   = DW - CW;
   localparam int CNT_W = $clog2(DW + 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCALE,
      S_WINDOW,
      S_CAND,
      S_LPF_TEST,
      S_DIV,
      S_DIV_END,
      S_POW4,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      DIV_TRIAL,
      DIV_LOWER,
      DIV_SCALE
   } purpose_type;

   state_type            state_ff, state_in;
   purpose_type          purpose_ff, purpose_in;
   logic                 cfg_pow4_ff, cfg_pow4_in;
   logic                 lower_ff, lower_in;
   logic                 lpf_only_ff, lpf_only_in;
   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic [CW-1:0]        i_ff, i_in;
   logic [CW-1:0]        lim_ff, lim_in;
   logic [CW-1:0]        best_ff, best_in;
   logic [CW-1:0]        bestpf_ff, bestpf_in;
   logic [CW-1:0]        n_ff, n_in;
   logic [CW-1:0]        f_ff, f_in;
   logic [CW:0]          fsq_ff, fsq_in;
   logic [CW-1:0]        den_ff, den_in;
   logic [CW-1:0]        rem_ff, rem_in;
   logic [DW-1:0]        dq_ff, dq_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [CW-1:0]        res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]        rsp_result_ff, rsp_result_in;

   // Divider step: shift in the next dividend bit and try the subtraction.
   logic [CW:0] trial;
   logic [CW:0] diff;
   logic        trial_ge;
   logic [CW:0] window_end;
   logic        better;

   assign trial      = {rem_ff, dq_ff[DW-1]};
   assign diff       = trial - {1'b0, den_ff};
   assign trial_ge   = (trial >= {1'b0, den_ff});
   assign window_end = {1'b0, i_ff} + {2'b0, i_ff[CW-1:1]};
   assign better     = lower_ff ? (n_ff <= bestpf_ff) : (n_ff < bestpf_ff);

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

   // Sequencer next-state logic.
   always_comb begin
      state_in      = state_ff;
      purpose_in    = purpose_ff;
      cfg_pow4_in   = csr_wr_en ? csr_wr_data : cfg_pow4_ff;
      lower_in      = lower_ff;
      lpf_only_in   = lpf_only_ff;
      size_in       = size_ff;
      i_in          = i_ff;
      lim_in        = lim_ff;
      best_in       = best_ff;
      bestpf_in     = bestpf_ff;
      n_in          = n_ff;
      f_in          = f_ff;
      fsq_in        = fsq_ff;
      den_in        = den_ff;
      rem_in        = rem_ff;
      dq_in         = dq_ff;
      cnt_in        = cnt_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_result_in = rsp_result_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               size_in     = req_size;
               lower_in    = (req_mode == MODE_LOWER);
               lpf_only_in = (req_mode == MODE_LPF);
               priority if (req_mode == MODE_LPF) begin
                  n_in     = CW'(req_size);
                  f_in     = CW'(TRIAL_FIRST);
                  fsq_in   = (CW+1)'(TRIAL_FIRST_SQ);
                  state_in = S_LPF_TEST;
               end else if (cfg_pow4_ff) begin
                  best_in  = CW'(POW4_MIN);
                  state_in = S_POW4;
               end else if (req_mode == MODE_LOWER) begin
                  // Divide 2 * size by three to find the window start.
                  den_in     = CW'(LOWER_DIVISOR);
                  rem_in     = '0;
                  dq_in      = DW'({req_size, 1'b0});
                  cnt_in     = CNT_W'(DW);
                  purpose_in = DIV_LOWER;
                  state_in   = S_DIV;
               end else if (req_mode == MODE_DOUBLE) begin
                  i_in     = CW'({req_size, 1'b0});
                  state_in = S_WINDOW;
               end else if (req_mode == MODE_THIRD) begin
                  // First part of size * 133, as size * 128 + size.
                  dq_in    = DW'({req_size, 7'b0}) + DW'(req_size);
                  state_in = S_SCALE;
               end else begin
                  i_in     = CW'(req_size);
                  state_in = S_WINDOW;
               end
            end
         end

         S_SCALE: begin
            // Add size * 4 and the rounding bias, then divide by 100.
            dq_in      = dq_ff + DW'({size_ff, 2'b0}) + DW'(SCALE_BIAS);
            den_in     = CW'(SCALE_DIVISOR);
            rem_in     = '0;
            cnt_in     = CNT_W'(DW);
            purpose_in = DIV_SCALE;
            state_in   = S_DIV;
         end

         S_WINDOW: begin
            // Upper search from the base up to 3 * base / 2, exclusive.
            best_in   = i_ff;
            bestpf_in = i_ff;
            lim_in    = window_end[CW-1:0];
            state_in  = S_CAND;
         end

         S_CAND: begin
            if (i_ff < lim_ff) begin
               n_in     = i_ff;
               f_in     = CW'(TRIAL_FIRST);
               fsq_in   = (CW+1)'(TRIAL_FIRST_SQ);
               state_in = S_LPF_TEST;
            end else begin
               res_in   = best_ff;
               state_in = S_DONE;
            end
         end

         S_LPF_TEST: begin
            if (fsq_ff <= {1'b0, n_ff}) begin
               // Trial divide n by f; n sits at the top of the shift register.
               den_in     = f_ff;
               rem_in     = '0;
               dq_in      = {n_ff, {PAD{1'b0}}};
               cnt_in     = CNT_W'(CW);
               purpose_in = DIV_TRIAL;
               state_in   = S_DIV;
            end else if (lpf_only_ff) begin
               res_in   = n_ff;
               state_in = S_DONE;
            end else begin
               if (better) begin
                  best_in   = i_ff;
                  bestpf_in = n_ff;
               end
               i_in     = i_ff + 1'b1;
               state_in = S_CAND;
            end
         end

         S_DIV: begin
            rem_in = trial_ge ? diff[CW-1:0] : trial[CW-1:0];
            dq_in  = {dq_ff[DW-2:0], trial_ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = S_DIV_END;
            end
         end

         S_DIV_END: begin
            unique case (purpose_ff)
               DIV_TRIAL: begin
                  // A dividing f is divided out, otherwise the next f is tried.
                  if (rem_ff == '0) begin
                     n_in = dq_ff[CW-1:0];
                  end else begin
                     f_in   = f_ff + 1'b1;
                     fsq_in = fsq_ff + {f_ff, 1'b1};
                  end
                  state_in = S_LPF_TEST;
               end
               DIV_LOWER: begin
                  // Lower search over 2 * size / 3 + 1 up to size, inclusive.
                  i_in      = dq_ff[CW-1:0] + 1'b1;
                  lim_in    = CW'(size_ff) + 1'b1;
                  best_in   = CW'(size_ff);
                  bestpf_in = CW'(size_ff);
                  state_in  = S_CAND;
               end
               DIV_SCALE: begin
                  i_in     = dq_ff[CW-1:0];
                  state_in = S_WINDOW;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         S_POW4: begin
            if (best_ff < CW'(size_ff)) begin
               best_in = {best_ff[CW-3:0], 2'b00};
            end else begin
               res_in   = lower_ff ? {2'b00, best_ff[CW-1:2]} : best_ff;
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            // Hand the result to the output register once it is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = res_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers and the registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         purpose_ff    <= DIV_TRIAL;
         cfg_pow4_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_result_ff <= '0;
         cnt_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         purpose_ff    <= purpose_in;
         cfg_pow4_ff   <= cfg_pow4_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_result_ff <= rsp_result_in;
         cnt_ff        <= cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      lower_ff      <= lower_in;
      lpf_only_ff   <= lpf_only_in;
      size_ff       <= size_in;
      i_ff          <= i_in;
      lim_ff        <= lim_in;
      best_ff       <= best_in;
      bestpf_ff     <= bestpf_in;
      n_ff          <= n_in;
      f_ff          <= f_in;
      fsq_ff        <= fsq_in;
      den_ff        <= den_in;
      rem_ff        <= rem_in;
      dq_ff         <= dq_in;
      res_ff        <= res_in;
   end

   // A transfer on the request side closes the request port for the next cycle.
   `SFSS_ASSERT_NEXT(a_req_closes, clock, reset, req_valid && req_ready, !req_ready)
   // The divider remainder always stays below the divisor.
   `SFSS_ASSERT_SAME(a_rem_below_den, clock, reset, state_ff == S_DIV, rem_ff < den_ff)
   // The divider only runs with steps left to do.
   `SFSS_ASSERT_SAME(a_div_count, clock, reset, state_ff == S_DIV, cnt_ff != '0)
   // The candidate index never runs past the window limit.
   `SFSS_ASSERT_SAME(a_cand_in_window, clock, reset, state_ff == S_CAND, i_ff <= lim_ff)

endmodule
